FILE: design/jet_pkg.sv
// jet_pkg: shared types, constants and helpers of the julia escape-time block
// used by jet_csr, jet_mul, julia_escape_time_top and both sim benches; depends on nothing
package jet_pkg;

   localparam int DATA_W  = 32;
   localparam int PROD_W  = 64;
   localparam int COUNT_W = 16;
   localparam int PIX_W   = 10;
   localparam int IDX_W   = 3;
   localparam int Q_FRAC  = 28;

   localparam logic [PROD_W-1:0] ESCAPE_MAG = 64'h0200_0000_0000_0000;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd256;

   localparam logic [IDX_W-1:0] REG_ORIGIN_RE  = 3'd0;
   localparam logic [IDX_W-1:0] REG_ORIGIN_IM  = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEP_RE    = 3'd2;
   localparam logic [IDX_W-1:0] REG_STEP_IM    = 3'd3;
   localparam logic [IDX_W-1:0] REG_CONST_RE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_CONST_IM   = 3'd5;
   localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

   typedef struct packed {
      logic signed [DATA_W-1:0] origin_re;
      logic signed [DATA_W-1:0] origin_im;
      logic signed [DATA_W-1:0] step_re;
      logic signed [DATA_W-1:0] step_im;
      logic signed [DATA_W-1:0] const_re;
      logic signed [DATA_W-1:0] const_im;
      logic [COUNT_W-1:0]       iter_limit;
   } cfg_type;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_MAP_RE  = 9'b000000010,
      S_MAP_IM  = 9'b000000100,
      S_MAP_FIN = 9'b000001000,
      S_RR      = 9'b000010000,
      S_II      = 9'b000100000,
      S_RI      = 9'b001000000,
      S_UPD     = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/jet_csr.sv
// jet_csr: configuration register file written through the csr port
// depends on jet_pkg for cfg_type and register indexes
module jet_csr import jet_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_RE:  cfg_in.origin_re  = csr_wdata;
            REG_ORIGIN_IM:  cfg_in.origin_im  = csr_wdata;
            REG_STEP_RE:    cfg_in.step_re    = csr_wdata;
            REG_STEP_IM:    cfg_in.step_im    = csr_wdata;
            REG_CONST_RE:   cfg_in.const_re   = csr_wdata;
            REG_CONST_IM:   cfg_in.const_im   = csr_wdata;
            REG_ITER_LIMIT: cfg_in.iter_limit = csr_wdata[COUNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_re:  '0,
                     origin_im:  '0,
                     step_re:    '0,
                     step_im:    '0,
                     const_re:   '0,
                     const_im:   '0,
                     iter_limit: LIMIT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/jet_mul.sv
// jet_mul: shared signed 32 x 32 multiplier with registered 64-bit product
// depends on jet_pkg for widths
module jet_mul import jet_pkg::*; (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] mul_a,
   input  logic signed [DATA_W-1:0] mul_b,
   output logic signed [PROD_W-1:0] mul_p
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

FILE: design/julia_escape_time_top.sv
// julia_escape_time_top: sequencer and datapath of the julia escape-time block
// depends on jet_pkg, jet_csr and jet_mul
//
// usage:
//   req channel carries one pixel (column, row) per item; rsp channel returns
//   its escape count. csr port writes the mapping, the constant c and the
//   iteration limit; write it only while no item is in flight.
// sequencing:
//   one shared multiplier forms every product, so each iteration steps through
//   the states re*re, im*im, re*im and update; mapping steps through S_MAP_RE,
//   S_MAP_IM and S_MAP_FIN. the next item can be taken in the cycle
//   after the count leaves the sequencer; req_tready is high only while the
//   sequencer is idle.
// reset:
//   synchronous reset empties the block and loads the register defaults
//   (all coordinates zero, limit 256).
// stall:
//   a waiting result sits in the output register; one more item is computed
//   and holds in the sequencer until the receiver takes the first.
module julia_escape_time_top import jet_pkg::*; #(
   parameter int MAX_DIM = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // escape_count[15:0]
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [DATA_W-1:0]   csr_wdata
);

   localparam logic [16:0] MAX_IDX = 17'(MAX_DIM - 1);

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [PIX_W-1:0]         px_ff, px_in, py_ff, py_in;
   logic signed [DATA_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PROD_W-1:0] rr_ff, rr_in, ii_ff, ii_in;
   logic [COUNT_W-1:0]       i_ff, i_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_data_ff, rsp_data_in;

   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [PIX_W-1:0]         px_clamp, py_clamp;
   logic [PROD_W-1:0]        mag;
   logic signed [PROD_W-1:0] map_re_sum, map_im_sum, nre_sum, nim_sum;
   logic [COUNT_W-1:0]       i_next;
   logic                     req_fire;

   jet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jet_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      px_clamp = req_tdata[9:0];
      py_clamp = req_tdata[19:10];
      if ({7'b0, req_tdata[9:0]} > MAX_IDX) begin
         px_clamp = MAX_IDX[PIX_W-1:0];
      end
      if ({7'b0, req_tdata[19:10]} > MAX_IDX) begin
         py_clamp = MAX_IDX[PIX_W-1:0];
      end
   end

   always_comb begin
      case (state_ff)
         S_MAP_RE: begin
            mul_a = DATA_W'(signed'({1'b0, px_ff}));
            mul_b = cfg.step_re;
         end
         S_MAP_IM: begin
            mul_a = DATA_W'(signed'({1'b0, py_ff}));
            mul_b = cfg.step_im;
         end
         S_RR: begin
            mul_a = re_ff;
            mul_b = re_ff;
         end
         S_II: begin
            mul_a = im_ff;
            mul_b = im_ff;
         end
         default: begin
            mul_a = re_ff;
            mul_b = im_ff;
         end
      endcase
   end

   assign map_re_sum = PROD_W'(cfg.origin_re) + mul_p;
   assign map_im_sum = -(PROD_W'(cfg.origin_im) + mul_p);
   assign mag        = rr_ff + mul_p;
   assign nre_sum    = ((rr_ff - ii_ff) >>> Q_FRAC) + PROD_W'(cfg.const_re);
   assign nim_sum    = (mul_p >>> (Q_FRAC - 1)) + PROD_W'(cfg.const_im);
   assign i_next     = i_ff + 16'd1;

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      i_in         = i_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               px_in    = px_clamp;
               py_in    = py_clamp;
               state_in = S_MAP_RE;
            end
         end
         S_MAP_RE: begin
            state_in = S_MAP_IM;
         end
         S_MAP_IM: begin
            re_in    = sat32(map_re_sum);
            state_in = S_MAP_FIN;
         end
         S_MAP_FIN: begin
            im_in = sat32(map_im_sum);
            i_in  = '0;
            if (cfg.iter_limit == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RR;
            end
         end
         S_RR: begin
            state_in = S_II;
         end
         S_II: begin
            rr_in    = mul_p;
            state_in = S_RI;
         end
         S_RI: begin
            ii_in = mul_p;
            if (mag > ESCAPE_MAG) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            re_in = sat32(nre_sum);
            im_in = sat32(nim_sum);
            i_in  = i_next;
            if (i_next == cfg.iter_limit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RR;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = i_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      i_ff        <= i_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RR || state_ff == S_II || state_ff == S_RI || state_ff == S_UPD)
      |-> (i_ff < cfg.iter_limit))
      else $error("iteration count reached the limit inside the loop");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (!req_tready && state_ff == S_MAP_RE))
      else $error("sequencer did not start after an accepted item");

   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_tvalid && rsp_tdata <= cfg.iter_limit))
      else $error("escape count above the iteration limit");

endmodule

FILE: sim/julia_escape_time_checker.sv
// julia_escape_time_checker: watches the req, rsp and csr ports of the julia
// escape-time block, predicts each escape count and compares it with the block
// depends on jet_pkg for widths, register indexes and the escape threshold
`timescale 1ns / 100ps

module julia_escape_time_checker import jet_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [23:0]       req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [15:0]       rsp_tdata,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_wdata,
   output int                mismatches,
   output int                outstanding,
   output int                verified
);

   localparam logic signed [PROD_W-1:0] Q28_TOP    = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] Q28_BOTTOM = -64'sd2147483648;

   typedef struct packed {
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic [COUNT_W-1:0] count;
   } pixel_count_type;

   logic signed [DATA_W-1:0] org_re, org_im, stp_re, stp_im, cst_re, cst_im;
   logic [COUNT_W-1:0]       lim;
   pixel_count_type          expected_counts[$];
   int                       errs = 0;
   int                       hits = 0;

   function automatic logic signed [DATA_W-1:0] clamp_q28(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > Q28_TOP) begin
         r = Q28_TOP[DATA_W-1:0];
      end else if (v < Q28_BOTTOM) begin
         r = Q28_BOTTOM[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] escape_count(input logic [PIX_W-1:0] col, row);
      logic signed [PROD_W-1:0] xi, yi, re, im, rr, ii, ri;
      logic [PROD_W-1:0]        mag;
      logic [COUNT_W-1:0]       n;
      logic                     escaped;
      int                       k;
      xi = {{(PROD_W-PIX_W){1'b0}}, col};
      yi = {{(PROD_W-PIX_W){1'b0}}, row};
      re = PROD_W'(clamp_q28(PROD_W'(org_re) + xi * PROD_W'(stp_re)));
      im = PROD_W'(clamp_q28(-(PROD_W'(org_im) + yi * PROD_W'(stp_im))));
      n = lim;
      escaped = 1'b0;
      for (k = 0; k < lim && !escaped; k++) begin
         rr = re * re;
         ii = im * im;
         ri = re * im;
         mag = rr + ii;
         if (mag > ESCAPE_MAG) begin
            n = COUNT_W'(k);
            escaped = 1'b1;
         end else begin
            // arithmetic shift of a signed product floors toward minus infinity
            re = PROD_W'(clamp_q28(((rr - ii) >>> Q_FRAC) + PROD_W'(cst_re)));
            im = PROD_W'(clamp_q28((ri >>> (Q_FRAC - 1)) + PROD_W'(cst_im)));
         end
      end
      return n;
   endfunction

   always @(posedge clock) begin
      pixel_count_type head;
      if (reset) begin
         org_re = '0;
         org_im = '0;
         stp_re = '0;
         stp_im = '0;
         cst_re = '0;
         cst_im = '0;
         lim = LIMIT_RESET;
         expected_counts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_RE:  org_re = csr_wdata;
               REG_ORIGIN_IM:  org_im = csr_wdata;
               REG_STEP_RE:    stp_re = csr_wdata;
               REG_STEP_IM:    stp_im = csr_wdata;
               REG_CONST_RE:   cst_re = csr_wdata;
               REG_CONST_IM:   cst_im = csr_wdata;
               REG_ITER_LIMIT: lim = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               errs++;
               if (errs <= 10) begin
                  $display("%t: unexpected escape count %0d with no pixel waiting",
                           $realtime, rsp_tdata);
               end
            end else begin
               head = expected_counts.pop_front();
               if (rsp_tdata !== head.count) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("%t: pixel (%0d, %0d) escape count expected %0d, got %0d",
                              $realtime, head.col, head.row, head.count, rsp_tdata);
                  end
               end else begin
                  hits++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            head.col = req_tdata[PIX_W-1:0];
            head.row = req_tdata[2*PIX_W-1:PIX_W];
            head.count = escape_count(head.col, head.row);
            expected_counts = {expected_counts, head};
         end
      end
      mismatches <= errs;
      outstanding <= expected_counts.size();
      verified <= hits;
   end

endmodule

FILE: sim/julia_escape_time_top_test.sv
// julia_escape_time_top_test: drives pixels and register settings into the
// julia escape-time block with random idling and stalls, and gives the verdict
// depends on jet_pkg, julia_escape_time_top and julia_escape_time_checker
`timescale 1ns / 100ps

module julia_escape_time_top_test;
   import jet_pkg::*;

   localparam logic [IDX_W-1:0]  REG_UNUSED  = 3'd7;
   localparam int                Q_ONE       = 268435456;
   localparam logic [DATA_W-1:0] Q_TWO_NEG   = 32'hE000_0000;
   localparam logic [DATA_W-1:0] VIEW_STEP   = 32'h0010_0000;
   localparam logic [DATA_W-1:0] JULIA_RE    = 32'hF333_3333;
   localparam logic [DATA_W-1:0] JULIA_IM    = 32'h027E_FA3F;
   localparam logic [DATA_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN       = 32'h8000_0000;
   localparam int                HOLD_CYCLES = 400;
   localparam int                RANDOM_PIXELS = 500;
   localparam logic [2*PIX_W-1:0] VIEW_PIXELS [8] = '{
      {10'd0, 10'd0}, {10'd0, 10'd1023}, {10'd1023, 10'd0}, {10'd1023, 10'd1023},
      {10'd512, 10'd512}, {10'd682, 10'd341}, {10'd300, 10'd700}, {10'd1, 10'd1}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic                csr_we = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [DATA_W-1:0]   csr_wdata = '0;

   int  mismatches, outstanding, verified;
   bit  steady = 1'b0;
   bit  hold_off = 1'b0;
   bit  hold_done = 1'b0;
   int  settings = 0;
   int  random_sent = 0;

   always #4 clock = ~clock;

   julia_escape_time_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_x[9:0], pixel_y[19:10], zero pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // escape_count[15:0]
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   julia_escape_time_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .verified    (verified)
   );

   initial begin
      #25_000_000;
      $display("julia_escape_time_top regression: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin : result_sink
      int stall;
      forever begin
         @(posedge clock);
         if (hold_off && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(1, 8);
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
      int gap;
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {4'd0, row, col};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_regs(input logic [DATA_W-1:0] o_re, o_im, s_re, s_im, c_re, c_im,
                             input logic [COUNT_W-1:0] limit);
      put_reg(REG_ORIGIN_RE, o_re);
      put_reg(REG_ORIGIN_IM, o_im);
      put_reg(REG_STEP_RE, s_re);
      put_reg(REG_STEP_IM, s_im);
      put_reg(REG_CONST_RE, c_re);
      put_reg(REG_CONST_IM, c_im);
      put_reg(REG_ITER_LIMIT, {16'd0, limit});
      // writes to the spare index must leave every register alone
      put_reg(REG_UNUSED, $urandom());
      csr_we <= 1'b0;
      settings++;
   endtask

   // picks a setting for one random run of pixels, returns the pixel count
   task automatic random_setting(output int n_pixels);
      int s_re, s_im, ctr_re, ctr_im, c_re, c_im;
      logic [COUNT_W-1:0] limit;
      n_pixels = $urandom_range(20, 50);
      case ($urandom_range(0, 7))
         0: begin
            limit = COUNT_W'($urandom_range(1, 32));
            write_regs($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), limit);
         end
         1: begin
            limit = COUNT_W'($urandom_range(0, 2));
            write_regs(Q_TWO_NEG, Q_TWO_NEG, VIEW_STEP, VIEW_STEP,
                       $urandom(), $urandom(), limit);
         end
         default: begin
            s_re = $urandom_range(1 << 16, 1 << 20);
            s_im = $urandom_range(1 << 16, 1 << 20);
            if ($urandom_range(0, 3) == 0) s_re = -s_re;
            if ($urandom_range(0, 3) == 0) s_im = -s_im;
            ctr_re = int'($urandom_range(0, Q_ONE)) - Q_ONE / 2;
            ctr_im = int'($urandom_range(0, Q_ONE)) - Q_ONE / 2;
            c_re = int'($urandom_range(0, 362387865)) - 241591910;
            c_im = int'($urandom_range(0, 429496730)) - 214748365;
            if ($urandom_range(0, 7) == 0) begin
               limit = COUNT_W'($urandom_range(65, 300));
               n_pixels = $urandom_range(5, 10);
            end else begin
               limit = COUNT_W'($urandom_range(8, 64));
            end
            write_regs(ctr_re - 512 * s_re, ctr_im - 512 * s_im, s_re, s_im,
                       c_re, c_im, limit);
         end
      endcase
   endtask

   initial begin
      int k, n_pixels;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: every pixel sits on the origin and never escapes
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      drain;

      // classic view of [-2, 2] around a well-known constant
      write_regs(Q_TWO_NEG, Q_TWO_NEG, VIEW_STEP, VIEW_STEP, JULIA_RE, JULIA_IM, 16'd64);
      foreach (VIEW_PIXELS[v]) send_pixel(VIEW_PIXELS[v][PIX_W-1:0], VIEW_PIXELS[v][2*PIX_W-1:PIX_W]);
      drain;

      // mapping saturates at the top end of the coordinate range
      write_regs(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 16'hFFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      drain;

      // first update lands on the extreme constants and the pixel then escapes
      write_regs('0, '0, '0, '0, Q_MAX, Q_MIN, 16'd16);
      send_pixel(10'd5, 10'd5);
      send_pixel(10'd1023, 10'd0);
      drain;

      // zero limit makes no test, limit of one makes a single test
      write_regs(Q_TWO_NEG, Q_TWO_NEG, VIEW_STEP, VIEW_STEP, JULIA_RE, JULIA_IM, 16'd0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd0, 10'd1023);
      drain;
      write_regs(Q_TWO_NEG, Q_TWO_NEG, VIEW_STEP, VIEW_STEP, JULIA_RE, JULIA_IM, 16'd1);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd0, 10'd0);
      drain;

      // largest limit on a fixed point at the origin
      write_regs('0, '0, '0, '0, '0, '0, 16'hFFFF);
      send_pixel(10'd700, 10'd3);
      drain;

      k = 0;
      while (random_sent < RANDOM_PIXELS) begin
         random_setting(n_pixels);
         if (k == 1) hold_off = 1'b1;
         repeat (n_pixels) begin
            if (random_sent >= RANDOM_PIXELS - 80) steady = 1'b1;
            send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
            random_sent++;
         end
         drain;
         k++;
      end

      repeat (20) @(posedge clock);
      $display("%0d escape counts matched over %0d register settings (limits 0 to 65535)",
               verified, settings);
      $display("with random idling on both sides and one %0d-cycle result hold-off",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("julia_escape_time_top regression: pass");
      end else begin
         $display("julia_escape_time_top regression: fail");
      end
      $finish;
   end

endmodule
